// ===== src/abcd_pkg.sv =====
// Shared types and constants for the alpha bleed color dilation block.
package abcd_pkg;

	localparam int CH_W  = 8;
	localparam int PIX_W = 32;
	localparam int SUM_W = 11;
	localparam int CNT_W = 4;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_READ = 1'b1;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef logic [2:0][SUM_W-1:0] sum3_t;
	typedef logic [2:0][CH_W-1:0]  chan3_t;

	typedef struct packed {
		logic             start;
		logic [CNT_W-1:0] cnt;
		sum3_t            sum;
	} div_req_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_FW_RD,
		ST_FW_WR,
		ST_BW_RD,
		ST_BW_RD2,
		ST_BW_WR,
		ST_FL_RD,
		ST_FL_CHK,
		ST_FL_NB,
		ST_FL_DIV
	} state_t;

endpackage

// ===== src/abcd_div.sv =====
// Bit-serial restoring divider for the three color channel sums.
module abcd_div (
	input  logic               clk,
	input  logic               arst_n,
	input  abcd_pkg::div_req_t req,
	output logic               done,
	output abcd_pkg::chan3_t   quot
);

	localparam int STEP_W = $clog2(abcd_pkg::SUM_W);

	logic                          busy_q;
	logic                          done_q;
	logic [STEP_W-1:0]             step_q;
	logic [abcd_pkg::CNT_W-1:0]    cnt_q;
	abcd_pkg::sum3_t               div_q;
	abcd_pkg::sum3_t               quo_q;
	logic [2:0][abcd_pkg::CNT_W-1:0] rem_q;
	logic [2:0][abcd_pkg::CNT_W-1:0] trial;
	logic [2:0][abcd_pkg::CNT_W-1:0] rem_d;
	logic [2:0]                    ge;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			trial[c] = {rem_q[c][abcd_pkg::CNT_W-2:0], div_q[c][abcd_pkg::SUM_W-1]};
			ge[c]    = (trial[c] >= cnt_q);
			rem_d[c] = ge[c] ? (trial[c] - cnt_q) : trial[c];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
			cnt_q  <= '0;
			div_q  <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
				cnt_q  <= req.cnt;
				div_q  <= req.sum;
				quo_q  <= '0;
				rem_q  <= '0;
			end else if (busy_q) begin
				for (int c = 0; c < 3; c++) begin
					rem_q[c] <= rem_d[c];
					div_q[c] <= {div_q[c][abcd_pkg::SUM_W-2:0], 1'b0};
					quo_q[c] <= {quo_q[c][abcd_pkg::SUM_W-2:0], ge[c]};
				end
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(abcd_pkg::SUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			quot[c] = quo_q[c][abcd_pkg::CH_W-1:0];
		end
	end

endmodule

// ===== src/alpha_bleed_color_dilation.sv =====
// Alpha bleed color dilation top level: image store, distance transform and fill sequencer.
//
//  channel | dir | handshake          | payload
//  s_*     | in  | s_tvalid/s_tready  | s_tdata {alpha,blue,green,red}, s_tuser cmd
//  m_*     | out | m_tvalid/m_tready  | m_tdata {alpha,blue,green,red}, m_tlast last_pixel
//  wr_*    | in  | wr_en              | wr_index, wr_data
//
// A load beat is written in IDLE; a read beat passes through ST_READ (one pixel
// memory read). After the last load: forward distance pass (FW_RD, FW_WR per
// pixel), backward pass (BW_RD, BW_RD2, BW_WR per pixel), then one fill sweep per
// distance level (FL_RD, FL_CHK a pixel; eight neighbor reads, divider for each pixel at that level).
// No beat is accepted while processing; arst_n clears all control state.
module alpha_bleed_color_dilation #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // red, green, blue, alpha
	input  logic        s_tuser,   // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // red, green, blue, alpha
	output logic        m_tlast,   // last_pixel
	input  logic        wr_en,
	input  logic        wr_index,
	input  logic [8:0]  wr_data
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int PW    = AW + 1;
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int XW    = $clog2(MAX_WIDTH);
	localparam int YW    = $clog2(MAX_HEIGHT);
	localparam int DW    = $clog2(MAX_WIDTH + MAX_HEIGHT);
	localparam logic [DW-1:0] INF = '1;
	localparam logic [WW-1:0] W_RST = WW'((MAX_WIDTH < 256) ? MAX_WIDTH : 256);
	localparam logic [HW-1:0] H_RST = HW'((MAX_HEIGHT < 256) ? MAX_HEIGHT : 256);

	abcd_pkg::state_t state_q, state_d;

	logic [WW-1:0] w_q;
	logic [HW-1:0] h_q;
	logic [PW-1:0] load_pos_q, read_pos_q, opq_q, n, opq_new;
	logic          processed_q, last_q;
	logic [AW-1:0] p_q;
	logic [XW-1:0] x_q;
	logic [YW-1:0] y_q;
	logic [DW-1:0] prev_q, cur_q, maxd_q, level_q;
	logic [2:0]    k_q, kk;
	logic          nbv_q;
	abcd_pkg::sum3_t sum_q, sum_n;
	logic [abcd_pkg::CNT_W-1:0] cnt_q, cnt_n;
	logic          m_tvalid_q, m_tlast_q;
	logic [31:0]   m_tdata_q;

	logic [abcd_pkg::PIX_W-1:0] pix_mem [DEPTH];
	logic [DW-1:0]              dist_mem [DEPTH];
	logic [abcd_pkg::PIX_W-1:0] pix_rd, pix_wd;
	logic [DW-1:0]              dist_rd, dist_wd;
	logic [AW-1:0]              pix_ra, pix_wa, dist_ra, dist_wa;
	logic                       pix_we, dist_we;

	abcd_pkg::div_req_t div_req;
	abcd_pkg::chan3_t   quot;
	logic               div_done;

	logic acc, load_ok, last_pix, x_first, x_end, y_first, y_end;
	logic dxm, dxp, dym, dyp, nb_ok;
	logic [AW-1:0] row, nb_addr, wa;
	logic [DW-1:0] fw_d, bw_d, up_i, left_i, down_i, right_i;

	function automatic logic [DW-1:0] sat_inc(input logic [DW-1:0] d);
		sat_inc = (d == INF) ? INF : d + DW'(1);
	endfunction

	function automatic logic [DW-1:0] dmin(input logic [DW-1:0] a, input logic [DW-1:0] b);
		dmin = (a < b) ? a : b;
	endfunction

	abcd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quot   (quot)
	);

	always_ff @(posedge clk) begin
		if (pix_we) pix_mem[pix_wa] <= pix_wd;
		pix_rd <= pix_mem[pix_ra];
	end

	always_ff @(posedge clk) begin
		if (dist_we) dist_mem[dist_wa] <= dist_wd;
		dist_rd <= dist_mem[dist_ra];
	end

	assign n        = PW'(w_q * h_q);
	assign wa       = AW'(w_q);
	assign s_tready = (state_q == abcd_pkg::ST_IDLE) && (!m_tvalid_q || m_tready);
	assign acc      = s_tvalid && s_tready;
	assign load_ok  = !processed_q && (load_pos_q < n);
	assign opq_new  = opq_q + PW'(s_tdata[31:24] != 8'h00);
	assign last_pix = (p_q == AW'(n - PW'(1)));
	assign x_first  = (x_q == '0);
	assign y_first  = (y_q == '0);
	assign x_end    = (x_q == XW'(w_q - WW'(1)));
	assign y_end    = (y_q == YW'(h_q - HW'(1)));

	// forward and backward distance candidates
	assign up_i    = y_first ? INF : sat_inc(dist_rd);
	assign left_i  = x_first ? INF : sat_inc(prev_q);
	assign fw_d    = (pix_rd[31:24] != 8'h00) ? '0 : dmin(up_i, left_i);
	assign down_i  = y_end ? INF : sat_inc(dist_rd);
	assign right_i = x_end ? INF : sat_inc(prev_q);
	assign bw_d    = dmin(cur_q, dmin(down_i, right_i));

	// neighbor selection for the fill
	assign kk = (state_q == abcd_pkg::ST_FL_NB) ? k_q + 3'd1 : 3'd0;
	always_comb begin
		dxm = 1'b0; dxp = 1'b0; dym = 1'b0; dyp = 1'b0;
		case (kk)
			3'd0: dxm = 1'b1;
			3'd1: dxp = 1'b1;
			3'd2: dym = 1'b1;
			3'd3: dyp = 1'b1;
			3'd4: begin dxm = 1'b1; dym = 1'b1; end
			3'd5: begin dxp = 1'b1; dym = 1'b1; end
			3'd6: begin dxm = 1'b1; dyp = 1'b1; end
			default: begin dxp = 1'b1; dyp = 1'b1; end
		endcase
		row     = dym ? p_q - wa : (dyp ? p_q + wa : p_q);
		nb_addr = dxm ? row - AW'(1) : (dxp ? row + AW'(1) : row);
		nb_ok   = !(dxm && x_first) && !(dxp && x_end) && !(dym && y_first) && !(dyp && y_end);
	end

	always_comb begin
		sum_n = sum_q;
		cnt_n = cnt_q;
		if (nbv_q && (dist_rd < level_q)) begin
			sum_n[0] = sum_q[0] + abcd_pkg::SUM_W'(pix_rd[7:0]);
			sum_n[1] = sum_q[1] + abcd_pkg::SUM_W'(pix_rd[15:8]);
			sum_n[2] = sum_q[2] + abcd_pkg::SUM_W'(pix_rd[23:16]);
			cnt_n    = cnt_q + abcd_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= abcd_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d       = state_q;
		pix_we        = 1'b0;
		pix_wa        = p_q;
		pix_wd        = {8'h00, quot[2], quot[1], quot[0]};
		pix_ra        = p_q;
		dist_we       = 1'b0;
		dist_wa       = p_q;
		dist_wd       = fw_d;
		dist_ra       = p_q;
		div_req.start = 1'b0;
		div_req.cnt   = cnt_n;
		div_req.sum   = sum_n;
		case (state_q)
			abcd_pkg::ST_IDLE: begin
				pix_ra = read_pos_q[AW-1:0];
				if (acc && s_tuser == abcd_pkg::CMD_LOAD && load_ok) begin
					pix_we = 1'b1;
					pix_wa = load_pos_q[AW-1:0];
					pix_wd = s_tdata;
					if (load_pos_q + PW'(1) == n && opq_new != '0 && opq_new != n)
						state_d = abcd_pkg::ST_FW_RD;
				end else if (acc && s_tuser == abcd_pkg::CMD_READ && processed_q) begin
					state_d = abcd_pkg::ST_READ;
				end
			end
			abcd_pkg::ST_READ: state_d = abcd_pkg::ST_IDLE;
			abcd_pkg::ST_FW_RD: begin
				dist_ra = p_q - wa;
				state_d = abcd_pkg::ST_FW_WR;
			end
			abcd_pkg::ST_FW_WR: begin
				dist_we = 1'b1;
				state_d = last_pix ? abcd_pkg::ST_BW_RD : abcd_pkg::ST_FW_RD;
			end
			abcd_pkg::ST_BW_RD: state_d = abcd_pkg::ST_BW_RD2;
			abcd_pkg::ST_BW_RD2: begin
				dist_ra = p_q + wa;
				state_d = abcd_pkg::ST_BW_WR;
			end
			abcd_pkg::ST_BW_WR: begin
				dist_we = 1'b1;
				dist_wd = bw_d;
				state_d = (p_q == '0) ? abcd_pkg::ST_FL_RD : abcd_pkg::ST_BW_RD;
			end
			abcd_pkg::ST_FL_RD: state_d = abcd_pkg::ST_FL_CHK;
			abcd_pkg::ST_FL_CHK: begin
				pix_ra  = nb_addr;
				dist_ra = nb_addr;
				if (dist_rd == level_q) state_d = abcd_pkg::ST_FL_NB;
				else if (last_pix && level_q == maxd_q) state_d = abcd_pkg::ST_IDLE;
				else state_d = abcd_pkg::ST_FL_RD;
			end
			abcd_pkg::ST_FL_NB: begin
				pix_ra  = nb_addr;
				dist_ra = nb_addr;
				if (k_q == 3'd7) begin
					div_req.start = 1'b1;
					state_d       = abcd_pkg::ST_FL_DIV;
				end
			end
			abcd_pkg::ST_FL_DIV: begin
				if (div_done) begin
					pix_we = 1'b1;
					if (last_pix && level_q == maxd_q) state_d = abcd_pkg::ST_IDLE;
					else state_d = abcd_pkg::ST_FL_RD;
				end
			end
			default: state_d = abcd_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q         <= W_RST;
			h_q         <= H_RST;
			load_pos_q  <= '0;
			read_pos_q  <= '0;
			opq_q       <= '0;
			processed_q <= 1'b0;
			last_q      <= 1'b0;
			p_q         <= '0;
			x_q         <= '0;
			y_q         <= '0;
			prev_q      <= '0;
			cur_q       <= '0;
			maxd_q      <= '0;
			level_q     <= '0;
			k_q         <= '0;
			nbv_q       <= 1'b0;
			sum_q       <= '0;
			cnt_q       <= '0;
			m_tvalid_q  <= 1'b0;
			m_tlast_q   <= 1'b0;
			m_tdata_q   <= '0;
		end else begin
			if (m_tvalid_q && m_tready) m_tvalid_q <= 1'b0;
			if (wr_en) begin
				if (wr_index == abcd_pkg::REG_WIDTH)
					w_q <= (wr_data == 9'd0) ? WW'(1) :
						((int'(wr_data) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(wr_data));
				else
					h_q <= (wr_data == 9'd0) ? HW'(1) :
						((int'(wr_data) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(wr_data));
				load_pos_q  <= '0;
				read_pos_q  <= '0;
				opq_q       <= '0;
				processed_q <= 1'b0;
			end
			case (state_q)
				abcd_pkg::ST_IDLE: begin
					if (acc && s_tuser == abcd_pkg::CMD_LOAD && load_ok) begin
						load_pos_q <= load_pos_q + PW'(1);
						opq_q      <= opq_new;
						p_q        <= '0;
						x_q        <= '0;
						y_q        <= '0;
						maxd_q     <= '0;
						level_q    <= DW'(1);
						if (load_pos_q + PW'(1) == n && (opq_new == '0 || opq_new == n))
							processed_q <= 1'b1;
					end else if (acc && s_tuser == abcd_pkg::CMD_READ && processed_q) begin
						last_q <= (read_pos_q == n - PW'(1));
					end
				end
				abcd_pkg::ST_READ: begin
					m_tvalid_q <= 1'b1;
					m_tdata_q  <= pix_rd;
					m_tlast_q  <= last_q;
					if (last_q) begin
						load_pos_q  <= '0;
						read_pos_q  <= '0;
						opq_q       <= '0;
						processed_q <= 1'b0;
					end else begin
						read_pos_q <= read_pos_q + PW'(1);
					end
				end
				abcd_pkg::ST_FW_WR: begin
					prev_q <= fw_d;
					if (last_pix) begin
						p_q <= p_q;
					end else begin
						p_q <= p_q + AW'(1);
						x_q <= x_end ? '0 : x_q + XW'(1);
						if (x_end) y_q <= y_q + YW'(1);
					end
				end
				abcd_pkg::ST_BW_RD2: cur_q <= dist_rd;
				abcd_pkg::ST_BW_WR: begin
					prev_q <= bw_d;
					if (bw_d > maxd_q) maxd_q <= bw_d;
					if (p_q == '0) begin
						x_q <= '0;
						y_q <= '0;
					end else begin
						p_q <= p_q - AW'(1);
						x_q <= x_first ? XW'(w_q - WW'(1)) : x_q - XW'(1);
						if (x_first) y_q <= y_q - YW'(1);
					end
				end
				abcd_pkg::ST_FL_CHK: begin
					k_q   <= '0;
					nbv_q <= nb_ok;
					sum_q <= '0;
					cnt_q <= '0;
					if (dist_rd != level_q) begin
						if (last_pix) begin
							if (level_q == maxd_q) processed_q <= 1'b1;
							level_q <= level_q + DW'(1);
							p_q <= '0;
							x_q <= '0;
							y_q <= '0;
						end else begin
							p_q <= p_q + AW'(1);
							x_q <= x_end ? '0 : x_q + XW'(1);
							if (x_end) y_q <= y_q + YW'(1);
						end
					end
				end
				abcd_pkg::ST_FL_NB: begin
					sum_q <= sum_n;
					cnt_q <= cnt_n;
					k_q   <= k_q + 3'd1;
					nbv_q <= nb_ok;
				end
				abcd_pkg::ST_FL_DIV: begin
					if (div_done) begin
						if (last_pix) begin
							if (level_q == maxd_q) processed_q <= 1'b1;
							level_q <= level_q + DW'(1);
							p_q <= '0;
							x_q <= '0;
							y_q <= '0;
						end else begin
							p_q <= p_q + AW'(1);
							x_q <= x_end ? '0 : x_q + XW'(1);
							if (x_end) y_q <= y_q + YW'(1);
						end
					end
				end
				default: ;
			endcase
			if (state_q == abcd_pkg::ST_FW_WR && last_pix) begin
				x_q <= XW'(w_q - WW'(1));
				y_q <= YW'(h_q - HW'(1));
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

endmodule

// ===== bench/alpha_bleed_color_dilation_tb.sv =====
// Self-checking testbench for the alpha bleed color dilation block.
module alpha_bleed_color_dilation_tb;

	localparam int MAXW       = 256;
	localparam int MAXH       = 256;
	localparam int UNSEEN     = 'hFFFF;
	localparam int QUIET_WAIT = 64;
	localparam int IDLE_LIMIT = 1000000;

	typedef struct {
		logic [31:0] pixel;
		logic        last;
	} readout_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // red, green, blue, alpha
	logic        s_tuser;   // cmd
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;   // red, green, blue, alpha
	logic        m_tlast;   // last_pixel
	logic        wr_en;
	logic        wr_index;
	logic [8:0]  wr_data;

	logic [31:0] pixel_mem [MAXW*MAXH];
	int          dist_mem [MAXW*MAXH];
	int          order_q [MAXW*MAXH];
	int          cfg_width;
	int          cfg_height;
	int          load_pos;
	int          read_pos;
	bit          processed;

	readout_t    pending_pixels[$];
	int          errors = 0;
	int          items_sent;
	bit          idle_on;
	int          stall_left = 0;
	int          idle_cycles = 0;

	alpha_bleed_color_dilation dut (.*);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic int eff_width();
		return (cfg_width < 1) ? 1 : (cfg_width > MAXW) ? MAXW : cfg_width;
	endfunction

	function automatic int eff_height();
		return (cfg_height < 1) ? 1 : (cfg_height > MAXH) ? MAXH : cfg_height;
	endfunction

	function automatic void dilate_image(int w, int h);
		int dxs[8] = '{-1, 1, 0, 0, -1, 1, -1, 1};
		int dys[8] = '{0, 0, -1, 1, -1, -1, 1, 1};
		int n, head, tail, opaque, q, x, y, nx, ny, np, d, cnt, r, g, b;
		n = w * h;
		tail = 0;
		for (int p = 0; p < n; p++) begin
			if (pixel_mem[p][31:24] != 8'd0) begin
				dist_mem[p] = 0;
				order_q[tail] = p;
				tail++;
			end else begin
				dist_mem[p] = UNSEEN;
			end
		end
		opaque = tail;
		if (opaque == 0 || opaque == n)
			return;
		head = 0;
		while (head < tail) begin
			q = order_q[head];
			head++;
			x = q % w;
			y = q / w;
			for (int k = 0; k < 4; k++) begin
				nx = x + dxs[k];
				ny = y + dys[k];
				if (nx < 0 || ny < 0 || nx >= w || ny >= h)
					continue;
				np = ny * w + nx;
				if (dist_mem[np] != UNSEEN)
					continue;
				dist_mem[np] = dist_mem[q] + 1;
				order_q[tail] = np;
				tail++;
			end
		end
		for (head = opaque; head < tail; head++) begin
			q = order_q[head];
			x = q % w;
			y = q / w;
			d = dist_mem[q];
			r = 0; g = 0; b = 0; cnt = 0;
			for (int k = 0; k < 8; k++) begin
				nx = x + dxs[k];
				ny = y + dys[k];
				if (nx < 0 || ny < 0 || nx >= w || ny >= h)
					continue;
				np = ny * w + nx;
				if (dist_mem[np] >= d)
					continue;
				r += int'(pixel_mem[np][7:0]);
				g += int'(pixel_mem[np][15:8]);
				b += int'(pixel_mem[np][23:16]);
				cnt++;
			end
			if (cnt != 0) begin
				pixel_mem[q][7:0]   = 8'(r / cnt);
				pixel_mem[q][15:8]  = 8'(g / cnt);
				pixel_mem[q][23:16] = 8'(b / cnt);
			end
		end
	endfunction

	function automatic void predict_beat(logic cmd, logic [31:0] data);
		int n;
		readout_t e;
		n = eff_width() * eff_height();
		if (cmd == abcd_pkg::CMD_LOAD) begin
			if (processed || load_pos >= n)
				return;
			pixel_mem[load_pos] = data;
			load_pos++;
			if (load_pos == n) begin
				dilate_image(eff_width(), eff_height());
				processed = 1'b1;
			end
		end else begin
			if (!processed || read_pos >= n)
				return;
			e.pixel = pixel_mem[read_pos];
			e.last  = (read_pos == n - 1);
			pending_pixels.push_back(e);
			if (e.last) begin
				load_pos = 0;
				read_pos = 0;
				processed = 1'b0;
			end else begin
				read_pos++;
			end
		end
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	task automatic send_beat(logic cmd, logic [31:0] data);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= data;
		do @(posedge clk); while (!s_tready);
		predict_beat(cmd, data);
		items_sent++;
	endtask

	task automatic wait_quiet();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (QUIET_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [8:0] val);
		wait_quiet();
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		if (idx == abcd_pkg::REG_WIDTH)
			cfg_width = int'(val);
		else
			cfg_height = int'(val);
		load_pos = 0;
		read_pos = 0;
		processed = 1'b0;
	endtask

	task automatic set_size(logic [8:0] w, logic [8:0] h);
		write_reg(abcd_pkg::REG_WIDTH, w);
		write_reg(abcd_pkg::REG_HEIGHT, h);
	endtask

	function automatic logic [31:0] rand_pixel(int clear_pct);
		logic [31:0] v;
		v = $urandom;
		if ($urandom_range(0, 99) < clear_pct)
			v[31:24] = 8'd0;
		return v;
	endfunction

	task automatic read_all();
		int n;
		n = eff_width() * eff_height();
		for (int i = 0; i < n; i++)
			send_beat(abcd_pkg::CMD_READ, $urandom);
	endtask

	task automatic run_image(int clear_pct, bit noise);
		int n;
		n = eff_width() * eff_height();
		for (int i = 0; i < n; i++) begin
			if (noise && $urandom_range(0, 15) == 0)
				send_beat(abcd_pkg::CMD_READ, $urandom);
			send_beat(abcd_pkg::CMD_LOAD, rand_pixel(clear_pct));
		end
		if (noise && $urandom_range(0, 3) == 0)
			send_beat(abcd_pkg::CMD_LOAD, $urandom);
		read_all();
	endtask

	task automatic test_directed();
		set_size(9'd4, 9'd3);
		send_beat(abcd_pkg::CMD_READ, 32'hFFFF_FFFF);
		send_beat(abcd_pkg::CMD_LOAD, 32'hFF00_0000);
		send_beat(abcd_pkg::CMD_LOAD, 32'h0000_0000);
		send_beat(abcd_pkg::CMD_LOAD, 32'h00FF_FFFF);
		send_beat(abcd_pkg::CMD_LOAD, 32'h01FF_FFFF);
		send_beat(abcd_pkg::CMD_LOAD, 32'hFFFF_FFFF);
		send_beat(abcd_pkg::CMD_READ, 32'h0);
		for (int i = 0; i < 6; i++)
			send_beat(abcd_pkg::CMD_LOAD, 32'h0055_AA33 << i);
		send_beat(abcd_pkg::CMD_LOAD, 32'hFFFF_FFFF);
		read_all();
		send_beat(abcd_pkg::CMD_READ, 32'h0);
	endtask

	task automatic test_uniform();
		set_size(9'd3, 9'd2);
		run_image(0, 1'b0);
		set_size(9'd2, 9'd3);
		run_image(100, 1'b0);
	endtask

	task automatic test_sizes();
		set_size(9'd0, 9'd0);
		run_image(50, 1'b0);
		set_size(9'd511, 9'd1);
		send_beat(abcd_pkg::CMD_LOAD, 32'h80C0_4020);
		for (int i = 1; i < 256; i++)
			send_beat(abcd_pkg::CMD_LOAD, rand_pixel(97));
		read_all();
		set_size(9'd1, 9'd300);
		for (int i = 0; i < 256; i++)
			send_beat(abcd_pkg::CMD_LOAD, (i == 255) ? 32'h0102_0304 : rand_pixel(98));
		read_all();
	endtask

	task automatic test_restart();
		set_size(9'd3, 9'd3);
		for (int i = 0; i < 5; i++)
			send_beat(abcd_pkg::CMD_LOAD, rand_pixel(50));
		write_reg(abcd_pkg::REG_WIDTH, 9'd2);
		run_image(60, 1'b0);
	endtask

	task automatic test_random();
		while (items_sent < 1500) begin
			set_size(9'($urandom_range(1, 10)), 9'($urandom_range(1, 10)));
			run_image($urandom_range(30, 90), 1'b1);
		end
	endtask

	task automatic test_no_idle();
		wait_quiet();
		idle_on = 1'b0;
		set_size(9'd6, 9'd5);
		run_image(70, 1'b0);
	endtask

	always @(posedge clk) begin
		readout_t e;
		if (idle_on) begin
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				m_tready <= 1'b0;
			end else if ($urandom_range(0, 5) == 0) begin
				stall_left <= $urandom_range(0, 6);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end else begin
			m_tready <= 1'b1;
		end
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_pixels.size() == 0) begin
				report("unexpected beat", m_tdata, 32'h0);
			end else begin
				e = pending_pixels.pop_front();
				if (m_tdata[7:0] !== e.pixel[7:0])
					report("red", 32'(m_tdata[7:0]), 32'(e.pixel[7:0]));
				if (m_tdata[15:8] !== e.pixel[15:8])
					report("green", 32'(m_tdata[15:8]), 32'(e.pixel[15:8]));
				if (m_tdata[23:16] !== e.pixel[23:16])
					report("blue", 32'(m_tdata[23:16]), 32'(e.pixel[23:16]));
				if (m_tdata[31:24] !== e.pixel[31:24])
					report("alpha", 32'(m_tdata[31:24]), 32'(e.pixel[31:24]));
				if (m_tlast !== e.last)
					report("last_pixel", 32'(m_tlast), 32'(e.last));
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		items_sent = 0;
		idle_on = 1'b1;
		cfg_width = 256;
		cfg_height = 256;
		load_pos = 0;
		read_pos = 0;
		processed = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = abcd_pkg::CMD_LOAD;
		wr_en = 1'b0;
		wr_index = abcd_pkg::REG_WIDTH;
		wr_data = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_uniform();
		test_sizes();
		test_restart();
		test_random();
		test_no_idle();
		wait_quiet();
		if (errors == 0 && pending_pixels.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
src/abcd_pkg.sv
src/abcd_div.sv
src/alpha_bleed_color_dilation.sv
bench/alpha_bleed_color_dilation_tb.sv
